// ===== hw/rtl/pkts_pkg.sv =====
// ----------------------------------------------------------------------------
// pkts_pkg: shared types and constants
// Event and report records, controller/datapath command and status groups,
// controller state encoding and register map constants.
// ----------------------------------------------------------------------------
`default_nettype none

package pkts_pkg;

    // Register map
    localparam int unsigned REG_IDX_W           = 1;
    localparam int unsigned PADDR_W             = 3;
    localparam logic [REG_IDX_W-1:0] REG_REPORT_INTERVAL = 1'b0;
    localparam logic [15:0] INTERVAL_RESET      = 16'd100;

    // One allocation event
    typedef struct packed {
        logic [15:0] user_id;
        logic [63:0] timestamp;
        logic [9:0]  frame_number;
        logic [7:0]  slot_number;
        logic [8:0]  first_block;
        logic [8:0]  block_count;
        logic [4:0]  coding_scheme;
        logic [31:0] transport_bytes;
        logic [3:0]  harq_process;
        logic        retransmission;
    } evt_t;

    // One report word
    typedef struct packed {
        evt_t        evt;
        logic [31:0] total_bytes;
        logic [31:0] alloc_count;
    } rpt_t;

    // Controller -> datapath
    typedef struct packed {
        logic load;
        logic scan;
        logic commit_hit;
        logic commit_miss;
    } ctrl_cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic match;
        logic scan_done;
        logic hit_report;
        logic out_free;
    } dp_status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_HIT,
        ST_MISS
    } state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/pkts_evt_if.sv =====
// ----------------------------------------------------------------------------
// pkts_evt_if: allocation event channel
// Valid/ready channel carrying one allocation event per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface pkts_evt_if;
    logic        valid;
    logic        ready;
    logic [15:0] user_id;
    logic [63:0] timestamp;
    logic [9:0]  frame_number;
    logic [7:0]  slot_number;
    logic [8:0]  first_block;
    logic [8:0]  block_count;
    logic [4:0]  coding_scheme;
    logic [31:0] transport_bytes;
    logic [3:0]  harq_process;
    logic        retransmission;

    modport source (
        output valid, user_id, timestamp, frame_number, slot_number, first_block,
               block_count, coding_scheme, transport_bytes, harq_process,
               retransmission,
        input  ready
    );

    modport sink (
        input  valid, user_id, timestamp, frame_number, slot_number, first_block,
               block_count, coding_scheme, transport_bytes, harq_process,
               retransmission,
        output ready
    );
endinterface

`default_nettype wire

// ===== hw/rtl/pkts_rpt_if.sv =====
// ----------------------------------------------------------------------------
// pkts_rpt_if: statistics report channel
// Valid/ready channel carrying one per-user report per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface pkts_rpt_if;
    logic        valid;
    logic        ready;
    logic [63:0] out_timestamp;
    logic [15:0] out_user_id;
    logic [9:0]  out_frame;
    logic [7:0]  out_slot;
    logic [8:0]  out_first_block;
    logic [8:0]  out_block_count;
    logic [4:0]  out_coding_scheme;
    logic [31:0] out_transport_bytes;
    logic [3:0]  out_harq_process;
    logic        out_retransmission;
    logic [31:0] total_bytes;
    logic [31:0] alloc_count;

    modport source (
        output valid, out_timestamp, out_user_id, out_frame, out_slot,
               out_first_block, out_block_count, out_coding_scheme,
               out_transport_bytes, out_harq_process, out_retransmission,
               total_bytes, alloc_count,
        input  ready
    );

    modport sink (
        input  valid, out_timestamp, out_user_id, out_frame, out_slot,
               out_first_block, out_block_count, out_coding_scheme,
               out_transport_bytes, out_harq_process, out_retransmission,
               total_bytes, alloc_count,
        output ready
    );
endinterface

`default_nettype wire

// ===== hw/rtl/pkts_ctrl.sv =====
// ----------------------------------------------------------------------------
// pkts_ctrl: sequencing state machine
// Accepts an event, runs the table scan, then commits a hit update or an
// insert; a miss or a reporting hit first waits for the report register to be free.
// ----------------------------------------------------------------------------
`default_nettype none

module pkts_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 evt_valid,
    output logic                      evt_ready,
    input  wire pkts_pkg::dp_status_t status,
    output pkts_pkg::ctrl_cmd_t       cmd
);

    pkts_pkg::state_t state_reg;
    pkts_pkg::state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pkts_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pkts_pkg::ST_IDLE:
            begin
                if (evt_valid)
                begin
                    state_next = pkts_pkg::ST_SCAN;
                end
            end
            pkts_pkg::ST_SCAN:
            begin
                priority if (status.match)
                begin
                    state_next = pkts_pkg::ST_HIT;
                end
                else if (status.scan_done)
                begin
                    state_next = pkts_pkg::ST_MISS;
                end
                else
                begin
                    state_next = pkts_pkg::ST_SCAN;
                end
            end
            pkts_pkg::ST_HIT:
            begin
                if (!status.hit_report || status.out_free)
                begin
                    state_next = pkts_pkg::ST_IDLE;
                end
            end
            pkts_pkg::ST_MISS:
            begin
                if (status.out_free)
                begin
                    state_next = pkts_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pkts_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        evt_ready = 1'b0;
        cmd       = '0;
        unique case (state_reg)
            pkts_pkg::ST_IDLE:
            begin
                evt_ready = 1'b1;
                cmd.load  = evt_valid;
            end
            pkts_pkg::ST_SCAN:
            begin
                cmd.scan = 1'b1;
            end
            pkts_pkg::ST_HIT:
            begin
                cmd.commit_hit = !status.hit_report || status.out_free;
            end
            pkts_pkg::ST_MISS:
            begin
                cmd.commit_miss = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/pkts_dp.sv =====
// ----------------------------------------------------------------------------
// pkts_dp: table datapath
// Holds the per-user table memories and fill count, scans keys one entry
// per cycle, updates counters and drives the report output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pkts_dp #(
    parameter int unsigned TABLE_ENTRIES = 64
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire pkts_pkg::ctrl_cmd_t  cmd,
    output pkts_pkg::dp_status_t      status,
    input  wire logic [15:0]          interval,
    input  wire pkts_pkg::evt_t       evt,
    input  wire logic                 rpt_ready,
    output logic                      rpt_valid,
    output pkts_pkg::rpt_t            rpt
);

    localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam logic [CNT_W-1:0] DEPTH = CNT_W'(TABLE_ENTRIES);

    // Table storage; entries 0..count-1 are in use
    logic [15:0] key_mem   [TABLE_ENTRIES];
    logic [31:0] byte_mem  [TABLE_ENTRIES];
    logic [31:0] slot_mem  [TABLE_ENTRIES];
    logic [15:0] phase_mem [TABLE_ENTRIES];

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] scan_addr_reg;
    logic             chk_v_reg;
    logic [IDX_W-1:0] chk_idx_reg;
    logic [15:0]      rd_key_reg;
    logic [31:0]      rd_byte_reg;
    logic [31:0]      rd_slot_reg;
    logic [15:0]      rd_phase_reg;
    pkts_pkg::evt_t   evt_reg;
    logic             out_valid_reg;
    pkts_pkg::rpt_t   rpt_reg;

    logic             more;
    logic             match;
    logic             issue;
    logic [31:0]      hit_bytes;
    logic [31:0]      hit_slots;
    logic [16:0]      hit_phase;
    logic             hit_report;
    logic             room;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [31:0]      wr_byte;
    logic [31:0]      wr_slot;
    logic [15:0]      wr_phase;
    logic             load_out;
    logic [31:0]      out_bytes;
    logic [31:0]      out_slots;

    // Scan compare and read issue
    assign more  = scan_addr_reg < count_reg;
    assign match = chk_v_reg && (rd_key_reg == evt_reg.user_id);
    assign issue = cmd.scan && more && !match;

    // Hit update arithmetic; a zero interval behaves like one
    assign hit_bytes  = rd_byte_reg + evt_reg.transport_bytes;
    assign hit_slots  = rd_slot_reg + 32'd1;
    assign hit_phase  = {1'b0, rd_phase_reg} + 17'd1;
    assign hit_report = hit_phase >= {1'b0, interval};

    assign room = count_reg < DEPTH;

    // Table write selection
    always_comb
    begin
        wr_en    = 1'b0;
        wr_addr  = chk_idx_reg;
        wr_byte  = hit_bytes;
        wr_slot  = hit_slots;
        wr_phase = hit_report ? 16'd0 : hit_phase[15:0];
        if (cmd.commit_miss)
        begin
            wr_en    = room;
            wr_addr  = count_reg[IDX_W-1:0];
            wr_byte  = evt_reg.transport_bytes;
            wr_slot  = 32'd1;
            wr_phase = (interval <= 16'd1) ? 16'd0 : 16'd1;
        end
        else if (cmd.commit_hit)
        begin
            wr_en = 1'b1;
        end
    end

    // Report load selection
    assign load_out  = cmd.commit_miss || (cmd.commit_hit && hit_report);
    assign out_bytes = cmd.commit_miss ? evt_reg.transport_bytes : hit_bytes;
    assign out_slots = cmd.commit_miss ? 32'd1 : hit_slots;

    // Memory write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            key_mem[wr_addr]   <= evt_reg.user_id;
            byte_mem[wr_addr]  <= wr_byte;
            slot_mem[wr_addr]  <= wr_slot;
            phase_mem[wr_addr] <= wr_phase;
        end
    end

    // Memory read port, registered
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            rd_key_reg   <= key_mem[scan_addr_reg[IDX_W-1:0]];
            rd_byte_reg  <= byte_mem[scan_addr_reg[IDX_W-1:0]];
            rd_slot_reg  <= slot_mem[scan_addr_reg[IDX_W-1:0]];
            rd_phase_reg <= phase_mem[scan_addr_reg[IDX_W-1:0]];
            chk_idx_reg  <= scan_addr_reg[IDX_W-1:0];
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            evt_reg <= evt;
        end
        if (load_out)
        begin
            rpt_reg.evt         <= evt_reg;
            rpt_reg.total_bytes <= out_bytes;
            rpt_reg.alloc_count <= out_slots;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            scan_addr_reg <= '0;
            chk_v_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                scan_addr_reg <= '0;
                chk_v_reg     <= 1'b0;
            end
            else if (cmd.scan)
            begin
                chk_v_reg <= issue;
                if (issue)
                begin
                    scan_addr_reg <= scan_addr_reg + CNT_W'(1);
                end
            end
            if (cmd.commit_miss && room)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rpt_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.match      = match;
    assign status.scan_done  = !chk_v_reg && !more;
    assign status.hit_report = hit_report;
    assign status.out_free   = !out_valid_reg || rpt_ready;

    assign rpt_valid = out_valid_reg;
    assign rpt       = rpt_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/per_key_traffic_stats_table_top.sv =====
// ----------------------------------------------------------------------------
// per_key_traffic_stats_table_top: per-user downlink traffic statistics
// Associative per-user table of byte and allocation totals with periodic
// reporting, configured through an APB-style register port.
// ----------------------------------------------------------------------------
// Sequence: an accepted event is scanned against the filled table entries; a hit
// commits once its entry k matches, a miss once every filled entry is checked.
// The report word is valid from the commit edge on; a busy output stalls a miss
// commit or a reporting hit commit. Throughput: one event at a time, set by the
// key scan over the table memory at one entry per cycle.
// Reset: asynchronous, active low; empties the table, interval returns to 100.
`default_nettype none

module per_key_traffic_stats_table_top #(
    parameter int unsigned TABLE_ENTRIES = 64
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    pkts_evt_if.sink                           evt_ch,
    pkts_rpt_if.source                         rpt_ch,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [pkts_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);

    logic [15:0]            interval_reg;
    logic                   cfg_wr;
    logic [pkts_pkg::REG_IDX_W-1:0] reg_idx;
    pkts_pkg::ctrl_cmd_t    cmd;
    pkts_pkg::dp_status_t   status;
    pkts_pkg::evt_t         evt;
    pkts_pkg::rpt_t         rpt;
    logic                   evt_ready;
    logic                   rpt_valid;

    // Register port
    assign pready  = 1'b1;
    assign reg_idx = paddr[pkts_pkg::PADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && (reg_idx == pkts_pkg::REG_REPORT_INTERVAL);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_reg <= pkts_pkg::INTERVAL_RESET;
        end
        else if (cfg_wr)
        begin
            interval_reg <= pwdata[15:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (reg_idx == pkts_pkg::REG_REPORT_INTERVAL)
        begin
            prdata = {16'd0, interval_reg};
        end
    end

    // Event word in
    assign evt.user_id         = evt_ch.user_id;
    assign evt.timestamp       = evt_ch.timestamp;
    assign evt.frame_number    = evt_ch.frame_number;
    assign evt.slot_number     = evt_ch.slot_number;
    assign evt.first_block     = evt_ch.first_block;
    assign evt.block_count     = evt_ch.block_count;
    assign evt.coding_scheme   = evt_ch.coding_scheme;
    assign evt.transport_bytes = evt_ch.transport_bytes;
    assign evt.harq_process    = evt_ch.harq_process;
    assign evt.retransmission  = evt_ch.retransmission;
    assign evt_ch.ready        = evt_ready;

    pkts_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .evt_valid (evt_ch.valid),
        .evt_ready (evt_ready),
        .status    (status),
        .cmd       (cmd)
    );

    pkts_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .interval  (interval_reg),
        .evt       (evt),
        .rpt_ready (rpt_ch.ready),
        .rpt_valid (rpt_valid),
        .rpt       (rpt)
    );

    // Report word out
    assign rpt_ch.valid               = rpt_valid;
    assign rpt_ch.out_timestamp       = rpt.evt.timestamp;
    assign rpt_ch.out_user_id         = rpt.evt.user_id;
    assign rpt_ch.out_frame           = rpt.evt.frame_number;
    assign rpt_ch.out_slot            = rpt.evt.slot_number;
    assign rpt_ch.out_first_block     = rpt.evt.first_block;
    assign rpt_ch.out_block_count     = rpt.evt.block_count;
    assign rpt_ch.out_coding_scheme   = rpt.evt.coding_scheme;
    assign rpt_ch.out_transport_bytes = rpt.evt.transport_bytes;
    assign rpt_ch.out_harq_process    = rpt.evt.harq_process;
    assign rpt_ch.out_retransmission  = rpt.evt.retransmission;
    assign rpt_ch.total_bytes         = rpt.total_bytes;
    assign rpt_ch.alloc_count         = rpt.alloc_count;

endmodule

`default_nettype wire
